>>> hw/rtl/psu_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
package psu_pkg;

    localparam int MAX_LINE_BYTES  = 4096;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int POS_W           = $clog2(MAX_LINE_BYTES);
    localparam int PIX_IDX_W       = $clog2(MAX_PIXEL_BYTES);
    localparam int BPP_W           = 4;
    localparam int LEN_W           = 13;
    localparam int ADDR_W          = 3;

    // Register indexes (paddr bit 2)
    localparam logic REG_BPP = 1'b0;
    localparam logic REG_LEN = 1'b1;

    // Filter classes carried with each data item
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;
    localparam logic [2:0] FLT_BAD   = 3'd5;

    localparam logic [7:0] FLT_MAX_TYPE = 8'd4;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       image_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       line_end;
        logic       bad_filter;
    } out_item_t;

    typedef struct packed {
        logic [PIX_IDX_W-1:0] bpp_m1;
        logic [POS_W-1:0]     last_pos;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic [2:0]       kind;
        logic             first_row;
        logic             has_left;
        logic             last;
    } entry_t;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [7:0]         pick;
        sa = $signed({3'b000, a});
        sb = $signed({3'b000, b});
        sc = $signed({3'b000, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc)
            pick = a;
        else if (db <= dc)
            pick = b;
        else
            pick = c;
        return pick;
    endfunction

endpackage

>>> hw/rtl/psu_front.sv
// Front end: tracks line position and filter type, turns data bytes into queue entries.
module psu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  psu_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_stall,
    input  psu_pkg::in_item_t in_item,
    input  logic            q_full,
    output logic            push,
    output psu_pkg::entry_t push_entry
);
    import psu_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [2:0]       kind_reg;
    logic [2:0]       kind_next;
    logic             expect_reg;
    logic             expect_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic             accept;
    logic             is_filter;
    logic             last;

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign is_filter = expect_reg || in_item.image_start;
    assign last      = pos_reg >= cfg.last_pos;
    assign push      = accept && !is_filter;

    always_comb
    begin
        push_entry.data      = in_item.stream_byte;
        push_entry.pos       = pos_reg;
        push_entry.kind      = kind_reg;
        push_entry.first_row = first_row_reg;
        push_entry.has_left  = pos_reg > POS_W'(cfg.bpp_m1);
        push_entry.last      = last;
    end

    always_comb
    begin
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        expect_next    = expect_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (is_filter)
            begin
                // Filter type byte: classify and open the line
                pos_next    = '0;
                expect_next = 1'b0;
                kind_next   = (in_item.stream_byte > FLT_MAX_TYPE) ? FLT_BAD
                                                                   : in_item.stream_byte[2:0];
                if (in_item.image_start)
                    first_row_next = 1'b1;
            end
            else if (last)
            begin
                pos_next       = '0;
                expect_next    = 1'b1;
                first_row_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            kind_reg      <= FLT_NONE;
            expect_reg    <= 1'b1;
            first_row_reg <= 1'b1;
        end
        else
        begin
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            expect_reg    <= expect_next;
            first_row_reg <= first_row_next;
        end
    end

`ifndef SYNTHESIS
    a_start_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.image_start) |-> !push)
        else $error("image start item pushed as data");
`endif

endmodule

>>> hw/rtl/psu_queue.sv
// Two-entry queue between the front end and the reconstruction back end.
module psu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  psu_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output psu_pkg::entry_t head
);
    import psu_pkg::*;

    entry_t     slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

>>> hw/rtl/psu_back.sv
// Back end: line store, neighbour history and filter reconstruction into the output register.
module psu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  psu_pkg::cfg_t   cfg,
    input  logic            head_valid,
    input  psu_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output psu_pkg::out_item_t out_item
);
    import psu_pkg::*;

    logic [7:0] line_mem [0:MAX_LINE_BYTES-1];
    logic [7:0] rdata_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    entry_t     b1_reg;
    logic       b1_valid_reg;
    logic       b1_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;

    logic [7:0] left_hist_reg  [0:MAX_PIXEL_BYTES-1];
    logic [7:0] upper_hist_reg [0:MAX_PIXEL_BYTES-1];

    logic       fire;
    logic [7:0] nb_a;
    logic [7:0] nb_b;
    logic [7:0] nb_c;
    logic [8:0] avg_sum;
    logic [7:0] pred;
    logic [7:0] recon;

    assign fire      = b1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop       = head_valid && (!b1_valid_reg || fire);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        nb_a    = b1_reg.has_left ? left_hist_reg[cfg.bpp_m1] : 8'd0;
        nb_c    = b1_reg.has_left ? upper_hist_reg[cfg.bpp_m1] : 8'd0;
        nb_b    = b1_reg.first_row ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : rdata_reg);
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        case (b1_reg.kind)
            FLT_SUB:   pred = nb_a;
            FLT_UP:    pred = nb_b;
            FLT_AVG:   pred = avg_sum[8:1];
            FLT_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
            default:   pred = 8'd0;
        endcase
        recon = b1_reg.data + pred;
    end

    always_comb
    begin
        b1_valid_next  = pop || (b1_valid_reg && !fire);
        out_valid_next = fire || (out_valid_reg && out_stall);
    end

    // Line store: write the reconstructed byte, read the next item's upper byte
    always_ff @(posedge clk)
    begin
        if (fire)
            line_mem[b1_reg.pos] <= recon;
        if (pop)
            rdata_reg <= line_mem[head.pos];
    end

    // Forward a same-address write that the read above misses; load the stage and output registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fwd_hit_reg  <= fire && (b1_reg.pos == head.pos);
            fwd_data_reg <= recon;
            b1_reg       <= head;
        end
        if (fire)
        begin
            out_item_reg.pixel_byte <= recon;
            out_item_reg.line_end   <= b1_reg.last;
            out_item_reg.bad_filter <= b1_reg.kind == FLT_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                left_hist_reg[k]  <= 8'd0;
                upper_hist_reg[k] <= 8'd0;
            end
        end
        else if (fire)
        begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--)
            begin
                left_hist_reg[k]  <= left_hist_reg[k-1];
                upper_hist_reg[k] <= upper_hist_reg[k-1];
            end
            left_hist_reg[0]  <= recon;
            upper_hist_reg[0] <= nb_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_pop_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> b1_valid_reg)
        else $error("popped item lost before reconstruction");
    a_fire_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("reconstructed item not presented");
`endif

endmodule

>>> hw/rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: configuration registers, front end, queue, back end.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  in       | in_valid / in_stall       | in_item  {stream_byte, image_start}
//  out      | out_valid / out_stall     | out_item {pixel_byte, line_end, bad_filter}
//  config   | psel/penable/pwrite/pready| paddr[2] selects bytes_per_pixel or line_bytes
//
// One item per cycle sustained while out_stall stays low; a data byte reaches out_valid through
// the queue write at the edge that accepts it, the line store read and the reconstruction into
// the output register. Filter type bytes give no result but still take an input slot.
// in_stall rises only when the two-entry queue is full, i.e. when out_stall has backed up
// the back end. Reset clears control state and the neighbour history; the line store is
// not cleared and the first row after an image start ignores what it reads from it.
module png_scanline_unfilter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  psu_pkg::in_item_t           in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output psu_pkg::out_item_t          out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import psu_pkg::*;

    logic [BPP_W-1:0] bpp_reg;
    logic [BPP_W-1:0] bpp_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             cfg_write;
    cfg_t             cfg;

    logic             push;
    entry_t           push_entry;
    logic             q_full;
    logic             pop;
    logic             head_valid;
    entry_t           head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_LEN) ? {{(32-LEN_W){1'b0}}, len_reg}
                                             : {{(32-BPP_W){1'b0}}, bpp_reg};

    always_comb
    begin
        bpp_next = bpp_reg;
        len_next = len_reg;
        if (cfg_write)
        begin
            if (paddr[2] == REG_BPP)
                bpp_next = pwdata[BPP_W-1:0];
            else
                len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_W'(1);
            len_reg <= LEN_W'(1);
        end
        else
        begin
            bpp_reg <= bpp_next;
            len_reg <= len_next;
        end
    end

    // Clamp the registers into their working ranges
    always_comb
    begin
        if (bpp_reg == '0)
            cfg.bpp_m1 = '0;
        else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES))
            cfg.bpp_m1 = PIX_IDX_W'(MAX_PIXEL_BYTES - 1);
        else
            cfg.bpp_m1 = PIX_IDX_W'(bpp_reg - 1'b1);

        if (len_reg == '0)
            cfg.last_pos = '0;
        else if (len_reg > LEN_W'(MAX_LINE_BYTES))
            cfg.last_pos = POS_W'(MAX_LINE_BYTES - 1);
        else
            cfg.last_pos = POS_W'(len_reg - 1'b1);
    end

    psu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    psu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    psu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

>>> dv/png_scanline_unfilter_tb.sv
// Self-checking testbench for the PNG scanline unfilter: scoreboard class and top module.

class unfilter_scoreboard;
    logic [7:0]          prior_row [psu_pkg::MAX_LINE_BYTES];
    logic [7:0]          left_bytes [psu_pkg::MAX_PIXEL_BYTES];
    logic [7:0]          upper_left_bytes [psu_pkg::MAX_PIXEL_BYTES];
    int unsigned         column;
    logic [7:0]          row_filter;
    bit                  awaiting_filter;
    bit                  top_row;
    logic [3:0]          pixel_bytes;
    logic [12:0]         row_bytes;
    psu_pkg::out_item_t  pending_pixels [$];
    int                  mismatches;
    int                  pixels_checked;
    int                  bytes_taken;
    int                  flagged_pixels;

    function new();
        foreach (prior_row[i])
            prior_row[i] = 8'h00;
        foreach (left_bytes[i])
        begin
            left_bytes[i]       = 8'h00;
            upper_left_bytes[i] = 8'h00;
        end
        column          = 0;
        row_filter      = 8'h00;
        awaiting_filter = 1'b1;
        top_row         = 1'b1;
        pixel_bytes     = 4'd1;
        row_bytes       = 13'd1;
        mismatches      = 0;
        pixels_checked  = 0;
        bytes_taken     = 0;
        flagged_pixels  = 0;
    endfunction

    function int paeth_choice(int a, int b, int c);
        int da;
        int db;
        int dc;
        da = b - c;
        db = a - c;
        dc = a + b - 2 * c;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc)
            return a;
        return (db <= dc) ? b : c;
    endfunction

    // Advance the line state by one accepted item and queue the byte it produces.
    function void take_byte(psu_pkg::in_item_t item);
        int unsigned         step;
        int unsigned         span;
        int unsigned         a;
        int unsigned         b;
        int unsigned         c;
        int unsigned         sum;
        logic [7:0]          recon;
        bit                  last;
        psu_pkg::out_item_t  want;
        bytes_taken++;
        if (item.image_start)
        begin
            column          = 0;
            awaiting_filter = 1'b1;
            top_row         = 1'b1;
        end
        if (awaiting_filter)
        begin
            row_filter      = item.stream_byte;
            awaiting_filter = 1'b0;
            column          = 0;
            return;
        end
        step = (pixel_bytes == 0) ? 1 :
               (pixel_bytes > psu_pkg::MAX_PIXEL_BYTES) ? psu_pkg::MAX_PIXEL_BYTES : pixel_bytes;
        span = (row_bytes == 0) ? 1 :
               (row_bytes > psu_pkg::MAX_LINE_BYTES) ? psu_pkg::MAX_LINE_BYTES : row_bytes;
        if (column >= psu_pkg::MAX_LINE_BYTES)
            column = psu_pkg::MAX_LINE_BYTES - 1;
        a = (column >= step) ? left_bytes[step - 1] : 0;
        b = top_row ? 0 : prior_row[column];
        c = (column >= step) ? upper_left_bytes[step - 1] : 0;
        case (row_filter)
            8'(psu_pkg::FLT_SUB):   sum = item.stream_byte + a;
            8'(psu_pkg::FLT_UP):    sum = item.stream_byte + b;
            8'(psu_pkg::FLT_AVG):   sum = item.stream_byte + ((a + b) >> 1);
            8'(psu_pkg::FLT_PAETH): sum = item.stream_byte + paeth_choice(a, b, c);
            default:                sum = item.stream_byte;
        endcase
        recon = sum[7:0];
        for (int k = psu_pkg::MAX_PIXEL_BYTES - 1; k > 0; k--)
        begin
            left_bytes[k]       = left_bytes[k - 1];
            upper_left_bytes[k] = upper_left_bytes[k - 1];
        end
        left_bytes[0]       = recon;
        upper_left_bytes[0] = b[7:0];
        prior_row[column]   = recon;
        last = (column >= span - 1);
        if (last)
        begin
            column          = 0;
            awaiting_filter = 1'b1;
            top_row         = 1'b0;
        end
        else
            column = column + 1;
        want.pixel_byte = recon;
        want.line_end   = last;
        want.bad_filter = (row_filter > psu_pkg::FLT_MAX_TYPE);
        pending_pixels.push_back(want);
    endfunction

    function void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s after %0d results: expected %0h, got %0h",
                     what, pixels_checked, want, got);
    endfunction

    function void check_pixel(psu_pkg::out_item_t got);
        psu_pkg::out_item_t want;
        pixels_checked++;
        if (pending_pixels.size() == 0)
        begin
            flag_mismatch("unexpected item", 32'hffff_ffff, got);
            return;
        end
        want = pending_pixels.pop_front();
        if (want.bad_filter)
            flagged_pixels++;
        if (got.pixel_byte !== want.pixel_byte)
            flag_mismatch("pixel_byte", want.pixel_byte, got.pixel_byte);
        if (got.line_end !== want.line_end)
            flag_mismatch("line_end", want.line_end, got.line_end);
        if (got.bad_filter !== want.bad_filter)
            flag_mismatch("bad_filter", want.bad_filter, got.bad_filter);
    endfunction
endclass

module png_scanline_unfilter_tb;
    import psu_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_BYTES = 1000;
    localparam int LONG_LINE    = 200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    unfilter_scoreboard sb;
    bit                 idling_on;
    int                 holds_requested;
    int                 holds_served;
    int                 hold_left;
    int                 items_sent;
    int                 reg_writes;
    int                 images;

    png_scanline_unfilter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Output side: random stalls, plus a long hold whenever one is requested.
    initial
    begin
        out_stall    = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (holds_requested > holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else
                out_stall = idling_on && ($urandom_range(99) < 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_byte(in_item);
            if (out_valid && !out_stall)
                sb.check_pixel(out_item);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic [7:0] value, input logic start);
        @(negedge clk);
        while (idling_on && $urandom_range(99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item  = '{stream_byte: value, image_start: start};
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_row(input logic [7:0] filter, input logic start, input int count);
        send_item(filter, start);
        repeat (count)
            send_item(8'($urandom_range(255)), 1'b0);
    endtask

    // Drop valid, wait for every queued byte, then let the filter bytes settle.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_register(input logic idx, input int unsigned value);
        logic [31:0] mask;
        logic [31:0] readback;
        mask = (idx == REG_BPP) ? 32'h0000_000f : 32'h0000_1fff;
        @(negedge clk);
        paddr   = {idx, 2'b00};
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_BPP)
            sb.pixel_bytes = value[3:0];
        else
            sb.row_bytes = value[12:0];
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if ((readback & mask) !== (value & mask))
            sb.flag_mismatch("register readback", value & mask, readback & mask);
        reg_writes++;
    endtask

    function automatic int unsigned effective_length(input int unsigned written);
        if (written == 0)
            return 1;
        return (written > MAX_LINE_BYTES) ? MAX_LINE_BYTES : written;
    endfunction

    initial
    begin
        int unsigned bpp_set;
        int unsigned len_set;
        int unsigned row_len;
        int unsigned cut;
        int unsigned newlen;
        int unsigned rows;
        int          random_start;
        logic [7:0]  filter;
        bit          restart;
        in_valid        = 1'b0;
        in_item         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rst_n           = 1'b0;
        idling_on       = 1'b1;
        holds_requested = 0;
        items_sent      = 0;
        reg_writes      = 0;
        images          = 0;
        sb = new();
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every filter type on a short line, extreme bytes, restarts.
        set_register(REG_BPP, 1);
        set_register(REG_LEN, 3);
        send_item(8'(FLT_NONE), 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'(FLT_SUB), 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'(FLT_UP), 1'b0);
        send_item(8'h7f, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'(FLT_AVG), 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'(FLT_PAETH), 1'b0);
        send_item(8'h10, 1'b0);
        send_item(8'hf0, 1'b0);
        send_item(8'h33, 1'b0);
        // Unknown filter type, then an image start where data is due.
        send_item(8'hff, 1'b0);
        send_item(8'haa, 1'b0);
        send_item(8'h55, 1'b0);
        send_row(8'(FLT_PAETH), 1'b1, 3);
        send_row(FLT_MAX_TYPE + 8'd1, 1'b0, 2);
        // Shorten the line while two bytes are already in: the next byte ends it.
        pause_until_drained();
        set_register(REG_LEN, 2);
        send_item(8'h5a, 1'b0);
        send_row(8'(FLT_UP), 1'b0, 2);
        // Zero register values act as one.
        pause_until_drained();
        set_register(REG_BPP, 0);
        set_register(REG_LEN, 0);
        send_row(8'(FLT_SUB), 1'b1, 1);
        send_row(8'(FLT_UP), 1'b0, 1);

        // Long lines at the widest pixel, with a long output hold.
        pause_until_drained();
        set_register(REG_BPP, 15);
        set_register(REG_LEN, LONG_LINE);
        holds_requested++;
        send_row(8'(FLT_SUB), 1'b1, LONG_LINE);
        send_row(8'(FLT_PAETH), 1'b0, 60);
        pause_until_drained();
        set_register(REG_BPP, MAX_PIXEL_BYTES);
        set_register(REG_LEN, 8191);
        send_row(8'(FLT_AVG), 1'b1, 100);

        // Random images: mostly well-formed rows, some cut short or shortened mid line.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_BYTES)
        begin
            idling_on = (items_sent - random_start < 400) || (items_sent - random_start > 700);
            pause_until_drained();
            bpp_set = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
            case ($urandom_range(19))
                0:       len_set = 0;
                1, 2:    len_set = $urandom_range(200, 25);
                default: len_set = $urandom_range(24, 1);
            endcase
            set_register(REG_BPP, bpp_set);
            set_register(REG_LEN, len_set);
            row_len = effective_length(len_set);
            rows    = $urandom_range(6, 1);
            restart = 1'b1;
            images++;
            for (int r = 0; r < rows; r++)
            begin
                if ($urandom_range(9) == 0)
                    filter = 8'($urandom_range(255, FLT_MAX_TYPE + 1));
                else
                    filter = 8'($urandom_range(FLT_PAETH));
                send_item(filter, restart);
                restart = 1'b0;
                cut = row_len;
                if ($urandom_range(24) == 0)
                begin
                    // Break the line; the next filter byte restarts the image.
                    cut     = $urandom_range(row_len - 1);
                    restart = 1'b1;
                end
                for (int k = 0; k < cut; k++)
                begin
                    if (k > 0 && !restart && row_len > 1 && $urandom_range(199) == 0)
                    begin
                        pause_until_drained();
                        newlen = $urandom_range(row_len - 1, 1);
                        set_register(REG_LEN, newlen);
                        cut     = (k >= newlen - 1) ? k + 1 : newlen;
                        row_len = newlen;
                    end
                    send_item(8'($urandom_range(255)), 1'b0);
                end
            end
        end
        idling_on = 1'b1;
        pause_until_drained();

        $display("covered %0d stream items, %0d random images, %0d register writes",
                 sb.bytes_taken, images, reg_writes);
        $display("checked %0d reconstructed bytes, %0d of them on unknown-filter lines",
                 sb.pixels_checked, sb.flagged_pixels);
        if (sb.pending_pixels.size() != 0)
            $display("%0d expected items never came out", sb.pending_pixels.size());
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule
